/* design/bale_pkg.sv */
// ----------------------------------------------------------------------------
// bale_pkg: shared types and constants of the bounded array list engine
// Field widths of the item channels, operation and status codes, controller
// states, and the command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
package bale_pkg;

    // default sizing of the list
    localparam int unsigned DEPTH_DEF         = 8;
    localparam int unsigned KEY_WIDTH_DEF     = 32;
    localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

    // fixed widths of the channel fields
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned PAY_W    = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned FIDX_W   = 3;
    localparam int unsigned COUNT_W  = 4;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_SEARCH = 3'd2,
        KIND_DELETE = 3'd3,
        KIND_READ   = 3'd4
    } kind_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_BAD_POS   = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } status_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_UP,
        S_INS_WRITE,
        S_SHIFT_DOWN,
        S_SCAN,
        S_FETCH,
        S_FINISH
    } state_t;

    // walk pointer updates
    typedef enum logic [2:0] {
        WALK_HOLD,
        WALK_ZERO,
        WALK_POS,
        WALK_POS_NEXT,
        WALK_LAST,
        WALK_INC,
        WALK_DEC
    } walk_op_t;

    // write port address and data selection
    typedef enum logic [1:0] {
        WR_NEW_AT_COUNT,
        WR_NEW_AT_POS,
        WR_SHIFT_UP,
        WR_SHIFT_DOWN
    } wr_sel_t;

    // entry counter updates
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    // controller to datapath
    typedef struct packed {
        logic     load_item;
        walk_op_t walk_op;
        logic     wr_en;
        wr_sel_t  wr_sel;
        cnt_op_t  cnt_op;
        logic     res_we;
        status_t  res_status;
        logic     res_carry;
        logic     emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  full;
        logic  empty;
        logic  pos_gt_count;
        logic  pos_ge_count;
        logic  pos_is_last;
        logic  walk_at_pos;
        logic  walk_at_last;
        logic  key_match;
        logic  out_free;
    } flags_t;

endpackage

/* design/bale_ifs.sv */
// ----------------------------------------------------------------------------
// bale item channels
// Valid/ready channels for the operation items and for the result items.
// ----------------------------------------------------------------------------
interface bale_req_if;
    logic                            valid;
    logic                            ready;
    logic [bale_pkg::KIND_W-1:0]     kind;
    logic [bale_pkg::POS_W-1:0]      position;
    logic [bale_pkg::KEY_W-1:0]      entry_key;
    logic [bale_pkg::PAY_W-1:0]      entry_payload;

    modport source (
        output valid, kind, position, entry_key, entry_payload,
        input  ready
    );
    modport sink (
        input  valid, kind, position, entry_key, entry_payload,
        output ready
    );
endinterface

interface bale_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [bale_pkg::STATUS_W-1:0]   status;
    logic [bale_pkg::FIDX_W-1:0]     found_index;
    logic [bale_pkg::KEY_W-1:0]      out_key;
    logic [bale_pkg::PAY_W-1:0]      out_payload;
    logic [bale_pkg::COUNT_W-1:0]    entry_count;

    modport source (
        output valid, status, found_index, out_key, out_payload, entry_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_index, out_key, out_payload, entry_count,
        output ready
    );
endinterface

/* design/bounded_array_list_engine_core.sv */
// Early-out cases, append among them, go from decode straight to finish; a read
// passes through a fetch state first. Shifts and searches walk the entry memory
// (one write port, one registered read port) one entry a cycle.
// One item is in work at a time; the next is taken while a result waits in the
// output register. Reset clears the controller state, the entry count and the output valid only;
// entry memory contents are left undefined and never read before written.
// ----------------------------------------------------------------------------
// bounded_array_list_engine_core: bounded ordered list engine
// Append, insert, search, delete and read on a list of up to DEPTH entries,
// each a key and a payload word, with one status result per operation.
// ----------------------------------------------------------------------------
module bounded_array_list_engine_core #(
    parameter int unsigned DEPTH         = bale_pkg::DEPTH_DEF,
    parameter int unsigned KEY_WIDTH     = bale_pkg::KEY_WIDTH_DEF,
    parameter int unsigned PAYLOAD_WIDTH = bale_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    bale_req_if.sink       req,
    bale_rsp_if.source     rsp
);

    bale_pkg::cmd_t   cmd;
    bale_pkg::flags_t flags;
    logic             in_ready;

    assign req.ready = in_ready;

    // sequencer
    bale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .flags     (flags),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    // entry store and result path
    bale_dp #(
        .DEPTH         (DEPTH),
        .KEY_WIDTH     (KEY_WIDTH),
        .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .flags         (flags),
        .kind          (req.kind),
        .position      (req.position),
        .entry_key     (req.entry_key),
        .entry_payload (req.entry_payload),
        .out_valid     (rsp.valid),
        .out_ready     (rsp.ready),
        .status        (rsp.status),
        .found_index   (rsp.found_index),
        .out_key       (rsp.out_key),
        .out_payload   (rsp.out_payload),
        .entry_count   (rsp.entry_count)
    );

    // a result is only loaded into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> flags.out_free)
        else $error("result loaded over an untaken result");

    // a loaded result shows as valid in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> rsp.valid)
        else $error("loaded result not presented");

    // an accepted item closes the input until its work is done
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |=> !req.ready)
        else $error("input open while an item is in work");

    // the count never grows past a full list nor drops below empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_op == bale_pkg::CNT_INC |-> !flags.full) and
        (cmd.cnt_op == bale_pkg::CNT_DEC |-> !flags.empty))
        else $error("entry count out of range");

endmodule

/* design/bale_ctrl.sv */
// ----------------------------------------------------------------------------
// bale_ctrl: operation sequencer
// Decodes each accepted item against the list state, walks the entry store
// for shifts and searches, and hands the result to the output register.
// ----------------------------------------------------------------------------
module bale_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  bale_pkg::flags_t  flags,
    output logic              in_ready,
    output bale_pkg::cmd_t    cmd
);

    bale_pkg::state_t state_reg;
    bale_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bale_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bale_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = bale_pkg::S_DECODE;
                end
            end
            bale_pkg::S_DECODE:
            begin
                state_next = bale_pkg::S_FINISH;
                case (flags.kind)
                    bale_pkg::KIND_INSERT:
                    begin
                        if (!flags.full && !flags.pos_ge_count)
                        begin
                            state_next = bale_pkg::S_SHIFT_UP;
                        end
                    end
                    bale_pkg::KIND_SEARCH:
                    begin
                        if (!flags.empty)
                        begin
                            state_next = bale_pkg::S_SCAN;
                        end
                    end
                    bale_pkg::KIND_DELETE:
                    begin
                        if (!flags.empty && !flags.pos_ge_count && !flags.pos_is_last)
                        begin
                            state_next = bale_pkg::S_SHIFT_DOWN;
                        end
                    end
                    bale_pkg::KIND_READ:
                    begin
                        if (!flags.pos_ge_count)
                        begin
                            state_next = bale_pkg::S_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = bale_pkg::S_FINISH;
                    end
                endcase
            end
            bale_pkg::S_SHIFT_UP:
            begin
                if (flags.walk_at_pos)
                begin
                    state_next = bale_pkg::S_INS_WRITE;
                end
            end
            bale_pkg::S_INS_WRITE:
            begin
                state_next = bale_pkg::S_FINISH;
            end
            bale_pkg::S_SHIFT_DOWN:
            begin
                if (flags.walk_at_last)
                begin
                    state_next = bale_pkg::S_FINISH;
                end
            end
            bale_pkg::S_SCAN:
            begin
                if (flags.key_match || flags.walk_at_last)
                begin
                    state_next = bale_pkg::S_FINISH;
                end
            end
            bale_pkg::S_FETCH:
            begin
                state_next = bale_pkg::S_FINISH;
            end
            bale_pkg::S_FINISH:
            begin
                if (flags.out_free)
                begin
                    state_next = bale_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bale_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.walk_op    = bale_pkg::WALK_HOLD;
        cmd.wr_sel     = bale_pkg::WR_NEW_AT_COUNT;
        cmd.cnt_op     = bale_pkg::CNT_HOLD;
        cmd.res_status = bale_pkg::STAT_OK;
        case (state_reg)
            bale_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = req_valid;
            end
            bale_pkg::S_DECODE:
            begin
                cmd.res_we = 1'b1;
                case (flags.kind)
                    bale_pkg::KIND_APPEND:
                    begin
                        if (flags.full)
                        begin
                            cmd.res_status = bale_pkg::STAT_FULL;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = bale_pkg::WR_NEW_AT_COUNT;
                            cmd.cnt_op = bale_pkg::CNT_INC;
                        end
                    end
                    bale_pkg::KIND_INSERT:
                    begin
                        if (flags.full)
                        begin
                            cmd.res_status = bale_pkg::STAT_FULL;
                        end
                        else if (flags.pos_gt_count)
                        begin
                            cmd.res_status = bale_pkg::STAT_BAD_POS;
                        end
                        else if (flags.pos_ge_count)
                        begin
                            // insert at the end is an append
                            cmd.wr_en  = 1'b1;
                            cmd.wr_sel = bale_pkg::WR_NEW_AT_COUNT;
                            cmd.cnt_op = bale_pkg::CNT_INC;
                        end
                        else
                        begin
                            cmd.res_we  = 1'b0;
                            cmd.walk_op = bale_pkg::WALK_LAST;
                        end
                    end
                    bale_pkg::KIND_SEARCH:
                    begin
                        if (flags.empty)
                        begin
                            cmd.res_status = bale_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.res_we  = 1'b0;
                            cmd.walk_op = bale_pkg::WALK_ZERO;
                        end
                    end
                    bale_pkg::KIND_DELETE:
                    begin
                        if (flags.empty)
                        begin
                            cmd.res_status = bale_pkg::STAT_EMPTY;
                        end
                        else if (flags.pos_ge_count)
                        begin
                            cmd.res_status = bale_pkg::STAT_BAD_POS;
                        end
                        else if (flags.pos_is_last)
                        begin
                            // removing the last entry needs no shift
                            cmd.cnt_op = bale_pkg::CNT_DEC;
                        end
                        else
                        begin
                            cmd.res_we  = 1'b0;
                            cmd.walk_op = bale_pkg::WALK_POS_NEXT;
                        end
                    end
                    bale_pkg::KIND_READ:
                    begin
                        if (flags.pos_ge_count)
                        begin
                            cmd.res_status = bale_pkg::STAT_BAD_POS;
                        end
                        else
                        begin
                            cmd.res_we  = 1'b0;
                            cmd.walk_op = bale_pkg::WALK_POS;
                        end
                    end
                    default:
                    begin
                        // unused kinds report ok and change nothing
                        cmd.res_status = bale_pkg::STAT_OK;
                    end
                endcase
            end
            bale_pkg::S_SHIFT_UP:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bale_pkg::WR_SHIFT_UP;
                if (!flags.walk_at_pos)
                begin
                    cmd.walk_op = bale_pkg::WALK_DEC;
                end
            end
            bale_pkg::S_INS_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bale_pkg::WR_NEW_AT_POS;
                cmd.cnt_op = bale_pkg::CNT_INC;
                cmd.res_we = 1'b1;
            end
            bale_pkg::S_SHIFT_DOWN:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_sel = bale_pkg::WR_SHIFT_DOWN;
                if (flags.walk_at_last)
                begin
                    cmd.cnt_op = bale_pkg::CNT_DEC;
                    cmd.res_we = 1'b1;
                end
                else
                begin
                    cmd.walk_op = bale_pkg::WALK_INC;
                end
            end
            bale_pkg::S_SCAN:
            begin
                if (flags.key_match)
                begin
                    cmd.res_we    = 1'b1;
                    cmd.res_carry = 1'b1;
                end
                else if (flags.walk_at_last)
                begin
                    cmd.res_we     = 1'b1;
                    cmd.res_status = bale_pkg::STAT_NOT_FOUND;
                end
                else
                begin
                    cmd.walk_op = bale_pkg::WALK_INC;
                end
            end
            bale_pkg::S_FETCH:
            begin
                cmd.res_we    = 1'b1;
                cmd.res_carry = 1'b1;
            end
            bale_pkg::S_FINISH:
            begin
                cmd.emit = flags.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* design/bale_dp.sv */
// ----------------------------------------------------------------------------
// bale_dp: entry store and datapath
// Holds the latched item, the entry count, the entry memory with its walk
// pointer and registered read, the pending result and the output register.
// ----------------------------------------------------------------------------
module bale_dp #(
    parameter int unsigned DEPTH         = bale_pkg::DEPTH_DEF,
    parameter int unsigned KEY_WIDTH     = bale_pkg::KEY_WIDTH_DEF,
    parameter int unsigned PAYLOAD_WIDTH = bale_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bale_pkg::cmd_t                   cmd,
    output bale_pkg::flags_t                 flags,
    input  logic [bale_pkg::KIND_W-1:0]      kind,
    input  logic [bale_pkg::POS_W-1:0]       position,
    input  logic [bale_pkg::KEY_W-1:0]       entry_key,
    input  logic [bale_pkg::PAY_W-1:0]       entry_payload,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [bale_pkg::STATUS_W-1:0]    status,
    output logic [bale_pkg::FIDX_W-1:0]      found_index,
    output logic [bale_pkg::KEY_W-1:0]       out_key,
    output logic [bale_pkg::PAY_W-1:0]       out_payload,
    output logic [bale_pkg::COUNT_W-1:0]     entry_count
);

    localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned PW    = bale_pkg::POS_W;
    localparam int unsigned CMPW  = (CW > PW) ? CW : PW;
    localparam int unsigned EW    = KEY_WIDTH + PAYLOAD_WIDTH;
    localparam int unsigned FW    = bale_pkg::FIDX_W;
    localparam int unsigned OKW   = bale_pkg::KEY_W;
    localparam int unsigned OPW   = bale_pkg::PAY_W;
    localparam int unsigned OCW   = bale_pkg::COUNT_W;

    // latched item
    bale_pkg::kind_t          kind_reg;
    logic [PW-1:0]            pos_reg;
    logic [KEY_WIDTH-1:0]     key_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;

    // list state
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [IW-1:0]            walk_reg;
    logic [IW-1:0]            walk_next;
    logic [EW-1:0]            mem [DEPTH];
    logic [EW-1:0]            rdata_reg;
    logic [IW-1:0]            wr_addr;
    logic [EW-1:0]            wr_data;

    // pending result and output register
    bale_pkg::status_t        res_status_reg;
    logic                     res_carry_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [bale_pkg::STATUS_W-1:0] out_status_reg;
    logic [FW-1:0]            out_fidx_reg;
    logic [OKW-1:0]           out_key_reg;
    logic [OPW-1:0]           out_pay_reg;
    logic [OCW-1:0]           out_count_reg;

    logic [IW-1:0]            pos_idx;
    logic [IW-1:0]            last_idx;
    logic [CMPW-1:0]          pos_ext;
    logic [CMPW-1:0]          cnt_ext;
    logic [KEY_WIDTH-1:0]     rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;

    assign pos_idx  = IW'(pos_reg);
    assign last_idx = IW'(count_reg - CW'(1));
    assign pos_ext  = CMPW'(pos_reg);
    assign cnt_ext  = CMPW'(count_reg);
    assign rd_key   = rdata_reg[EW-1:PAYLOAD_WIDTH];
    assign rd_pay   = rdata_reg[PAYLOAD_WIDTH-1:0];

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            kind_reg <= bale_pkg::kind_t'(kind);
            pos_reg  <= position;
            key_reg  <= entry_key[KEY_WIDTH-1:0];
            pay_reg  <= entry_payload[PAYLOAD_WIDTH-1:0];
        end
    end

    // entry count
    always_comb
    begin
        case (cmd.cnt_op)
            bale_pkg::CNT_INC: count_next = count_reg + CW'(1);
            bale_pkg::CNT_DEC: count_next = count_reg - CW'(1);
            default:           count_next = count_reg;
        endcase
    end

    // walk pointer
    always_comb
    begin
        case (cmd.walk_op)
            bale_pkg::WALK_ZERO:     walk_next = '0;
            bale_pkg::WALK_POS:      walk_next = pos_idx;
            bale_pkg::WALK_POS_NEXT: walk_next = pos_idx + IW'(1);
            bale_pkg::WALK_LAST:     walk_next = last_idx;
            bale_pkg::WALK_INC:      walk_next = walk_reg + IW'(1);
            bale_pkg::WALK_DEC:      walk_next = walk_reg - IW'(1);
            default:                 walk_next = walk_reg;
        endcase
    end

    // write port selection
    always_comb
    begin
        case (cmd.wr_sel)
            bale_pkg::WR_NEW_AT_POS:
            begin
                wr_addr = pos_idx;
                wr_data = {key_reg, pay_reg};
            end
            bale_pkg::WR_SHIFT_UP:
            begin
                wr_addr = walk_reg + IW'(1);
                wr_data = rdata_reg;
            end
            bale_pkg::WR_SHIFT_DOWN:
            begin
                wr_addr = walk_reg - IW'(1);
                wr_data = rdata_reg;
            end
            default:
            begin
                wr_addr = IW'(count_reg);
                wr_data = {key_reg, pay_reg};
            end
        endcase
    end

    // entry memory, read data is registered alongside the walk pointer
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[walk_next];
    end

    // walk pointer, pending result and output payload
    always_ff @(posedge clk)
    begin
        walk_reg <= walk_next;
        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_status;
            res_carry_reg  <= cmd.res_carry;
        end
        if (cmd.emit)
        begin
            out_status_reg <= res_status_reg;
            // only a search reports the index it stopped at
            out_fidx_reg   <= (res_carry_reg && kind_reg == bale_pkg::KIND_SEARCH) ?
                              FW'(walk_reg) : '0;
            out_key_reg    <= res_carry_reg ? OKW'(rd_key) : '0;
            out_pay_reg    <= res_carry_reg ? OPW'(rd_pay) : '0;
            out_count_reg  <= OCW'(count_reg);
        end
    end

    // output handshake
    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // status towards the controller
    always_comb
    begin
        flags.kind         = kind_reg;
        flags.full         = (count_reg == CW'(DEPTH));
        flags.empty        = (count_reg == '0);
        flags.pos_gt_count = (pos_ext > cnt_ext);
        flags.pos_ge_count = (pos_ext >= cnt_ext);
        flags.pos_is_last  = (({1'b0, pos_ext} + (CMPW + 1)'(1)) == {1'b0, cnt_ext});
        flags.walk_at_pos  = (walk_reg == pos_idx);
        flags.walk_at_last = (walk_reg == last_idx);
        flags.key_match    = (rd_key == key_reg);
        flags.out_free     = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_index = out_fidx_reg;
    assign out_key     = out_key_reg;
    assign out_payload = out_pay_reg;
    assign entry_count = out_count_reg;

endmodule

/* dv/tb_bounded_array_list_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_array_list_engine_core: self-checking bench of the list engine
// Drives operation items through the request channel and mirrors the list in
// a behavioural copy kept in the bench. Each result item is compared field by
// field with the oldest predicted one. Directed cases cover the empty and full
// list, bad positions, duplicate keys and spare kinds; random traffic follows
// with fill and drain phases, random idling on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_bounded_array_list_engine_core;
    import bale_pkg::*;

    localparam int unsigned LIST_DEPTH = DEPTH_DEF;
    localparam int          MIRROR_IW  = $clog2(LIST_DEPTH);
    localparam int          IDLE_LIMIT = 2000;
    localparam int          RANDOM_OPS = 1900;
    localparam int          DRAIN_WAIT = 20;

    // kinds that the block must ignore
    localparam logic [KIND_W-1:0] KIND_SPARE_5 = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  position;
        logic [KEY_W-1:0]  key;
        logic [PAY_W-1:0]  payload;
    } list_op_t;

    typedef struct packed {
        status_t              status;
        logic [FIDX_W-1:0]    found_index;
        logic [KEY_W-1:0]     out_key;
        logic [PAY_W-1:0]     out_payload;
        logic [COUNT_W-1:0]   entry_count;
    } list_reply_t;

    logic clk;
    logic rst_n;

    bale_req_if req_ch ();
    bale_rsp_if rsp_ch ();

    bounded_array_list_engine_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // mirror of the list held by the block
    logic [KEY_W-1:0] mirror_key     [LIST_DEPTH];
    logic [PAY_W-1:0] mirror_payload [LIST_DEPTH];
    int               mirror_count;

    list_reply_t replies_due[$];
    int          n_errors = 0;
    int          quiet_cycles = 0;
    bit          req_steady;
    bit          rsp_steady;
    int          rsp_hold_cycles;

    // clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // apply one operation to the mirror and work out its result
    function automatic list_reply_t run_list_op(list_op_t op);
        list_reply_t r;
        int          i;
        bit          hit;
        r = '0;
        r.status = STAT_OK;
        hit = 1'b0;
        case (op.kind)
            KIND_APPEND:
            begin
                if (mirror_count >= LIST_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    mirror_key[MIRROR_IW'(mirror_count)]     = op.key;
                    mirror_payload[MIRROR_IW'(mirror_count)] = op.payload;
                    mirror_count++;
                end
            end
            KIND_INSERT:
            begin
                if (mirror_count >= LIST_DEPTH)
                    r.status = STAT_FULL;
                else if (op.position > mirror_count)
                    r.status = STAT_BAD_POS;
                else
                begin
                    for (i = mirror_count; i > op.position; i--)
                    begin
                        mirror_key[MIRROR_IW'(i)]     = mirror_key[MIRROR_IW'(i-1)];
                        mirror_payload[MIRROR_IW'(i)] = mirror_payload[MIRROR_IW'(i-1)];
                    end
                    mirror_key[MIRROR_IW'(op.position)]     = op.key;
                    mirror_payload[MIRROR_IW'(op.position)] = op.payload;
                    mirror_count++;
                end
            end
            KIND_SEARCH:
            begin
                if (mirror_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    r.status = STAT_NOT_FOUND;
                    for (i = 0; i < mirror_count; i++)
                    begin
                        if (!hit && mirror_key[MIRROR_IW'(i)] == op.key)
                        begin
                            hit           = 1'b1;
                            r.status      = STAT_OK;
                            r.found_index = i[FIDX_W-1:0];
                            r.out_key     = mirror_key[MIRROR_IW'(i)];
                            r.out_payload = mirror_payload[MIRROR_IW'(i)];
                        end
                    end
                end
            end
            KIND_DELETE:
            begin
                if (mirror_count == 0)
                    r.status = STAT_EMPTY;
                else if (op.position >= mirror_count)
                    r.status = STAT_BAD_POS;
                else
                begin
                    for (i = op.position; i + 1 < mirror_count; i++)
                    begin
                        mirror_key[MIRROR_IW'(i)]     = mirror_key[MIRROR_IW'(i+1)];
                        mirror_payload[MIRROR_IW'(i)] = mirror_payload[MIRROR_IW'(i+1)];
                    end
                    mirror_count--;
                end
            end
            KIND_READ:
            begin
                if (op.position >= mirror_count)
                    r.status = STAT_BAD_POS;
                else
                begin
                    r.out_key     = mirror_key[MIRROR_IW'(op.position)];
                    r.out_payload = mirror_payload[MIRROR_IW'(op.position)];
                end
            end
            default:
            begin
            end
        endcase
        r.entry_count = mirror_count[COUNT_W-1:0];
        return r;
    endfunction

    // random operation shaped by the current fill of the list
    function automatic list_op_t pick_list_op(int grow_pct);
        list_op_t op;
        int       r;
        op.key      = $urandom;
        op.payload  = $urandom;
        op.position = '0;
        // small key pool gives duplicate keys and search hits
        if ($urandom_range(0, 3) == 0)
            op.key = $urandom_range(0, 3);
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            op.kind     = KIND_W'($urandom_range(5, 7));
            op.position = POS_W'($urandom_range(0, 15));
        end
        else if (r < 9)
        begin
            // noise: any operation at any position
            op.kind     = KIND_W'($urandom_range(0, 4));
            op.position = POS_W'($urandom_range(0, 15));
        end
        else if ($urandom_range(0, 99) < grow_pct)
        begin
            op.kind     = $urandom_range(0, 1) ? KIND_APPEND : KIND_INSERT;
            op.position = POS_W'($urandom_range(0, mirror_count));
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       op.kind = KIND_DELETE;
                1:       op.kind = KIND_READ;
                default: op.kind = KIND_SEARCH;
            endcase
            if (mirror_count > 0)
            begin
                op.position = POS_W'($urandom_range(0, mirror_count - 1));
                if (op.kind == KIND_SEARCH && $urandom_range(0, 3) != 0)
                    op.key = mirror_key[MIRROR_IW'($urandom_range(0, mirror_count - 1))];
            end
        end
        return op;
    endfunction

    // offer one item, wait for it to be taken, then predict its result
    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] position,
                           input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] payload);
        list_op_t op;
        int       gap;
        op.kind     = kind;
        op.position = position;
        op.key      = key;
        op.payload  = payload;
        gap = req_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= op.kind;
        req_ch.position      <= op.position;
        req_ch.entry_key     <= op.key;
        req_ch.entry_payload <= op.payload;
        do
            @(posedge clk);
        while (!req_ch.ready);
        replies_due.push_back(run_list_op(op));
    endtask

    // empty list: every operation that can fail on it, and the spare kinds
    task automatic test_empty_list();
        send_op(KIND_SEARCH, 4'd0, 32'h0000_0000, 32'h0000_0000);
        send_op(KIND_DELETE, 4'd0, 32'h0000_0000, 32'h0000_0000);
        send_op(KIND_READ, 4'd0, 32'h0000_0000, 32'h0000_0000);
        send_op(KIND_INSERT, 4'd1, 32'hffff_ffff, 32'hffff_ffff);
        send_op(KIND_SPARE_5, 4'd15, 32'hffff_ffff, 32'hffff_ffff);
        send_op(KIND_SPARE_6, 4'd8, 32'h8000_0001, 32'h0000_0001);
        send_op(KIND_SPARE_7, 4'd7, 32'h0000_0000, 32'hffff_ffff);
    endtask

    // fill to full, then probe the edges and drain partly
    task automatic test_fill_and_edges();
        send_op(KIND_INSERT, 4'd0, 32'hffff_ffff, 32'h0000_0000);
        send_op(KIND_APPEND, 4'd0, 32'h0000_0000, 32'hffff_ffff);
        send_op(KIND_INSERT, 4'd2, 32'h0000_0005, 32'h1111_1111);
        send_op(KIND_INSERT, 4'd1, 32'h0000_0005, 32'h2222_2222);
        send_op(KIND_APPEND, 4'd0, 32'h0000_0011, 32'h3333_3333);
        send_op(KIND_APPEND, 4'd0, 32'h0000_0012, 32'h4444_4444);
        send_op(KIND_APPEND, 4'd0, 32'h0000_0013, 32'h5555_5555);
        send_op(KIND_APPEND, 4'd0, 32'h0000_0014, 32'h6666_6666);
        // full check takes precedence over the position check
        send_op(KIND_APPEND, 4'd0, 32'h0000_0015, 32'h7777_7777);
        send_op(KIND_INSERT, 4'd15, 32'h0000_0016, 32'h8888_8888);
        send_op(KIND_READ, 4'd7, 32'h0000_0000, 32'h0000_0000);
        send_op(KIND_READ, 4'd8, 32'h0000_0000, 32'h0000_0000);
        // duplicate key returns the lowest index
        send_op(KIND_SEARCH, 4'd0, 32'h0000_0005, 32'h0000_0000);
        send_op(KIND_SEARCH, 4'd0, 32'h1234_5678, 32'h0000_0000);
        send_op(KIND_DELETE, 4'd8, 32'h0000_0000, 32'h0000_0000);
        send_op(KIND_DELETE, 4'd7, 32'h0000_0000, 32'h0000_0000);
        send_op(KIND_DELETE, 4'd0, 32'h0000_0000, 32'h0000_0000);
        send_op(KIND_INSERT, 4'd3, 32'h0000_0021, 32'h9999_9999);
    endtask

    // receiver holds off while items keep coming back to back
    task automatic test_output_stall();
        list_op_t op;
        rsp_hold_cycles = 100;
        req_steady      = 1'b1;
        repeat (12)
        begin
            op = pick_list_op(50);
            send_op(op.kind, op.position, op.key, op.payload);
        end
        req_steady = 1'b0;
    endtask

    // random traffic in fill and drain phases
    task automatic test_random_traffic();
        list_op_t op;
        int       grow_pct;
        int       n;
        grow_pct = 50;
        for (n = 0; n < RANDOM_OPS; n++)
        begin
            if (n % 60 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       grow_pct = 85;
                    1:       grow_pct = 50;
                    default: grow_pct = 15;
                endcase
                req_steady = ($urandom_range(0, 3) == 0);
                rsp_steady = ($urandom_range(0, 3) == 0);
            end
            op = pick_list_op(grow_pct);
            send_op(op.kind, op.position, op.key, op.payload);
        end
        req_steady = 1'b0;
        rsp_steady = 1'b0;
    endtask

    // result side: random stalls per item, one long hold-off on request
    initial
    begin : accept_results
        int stall;
        bit hold_done;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rsp_hold_cycles > 0 && !hold_done)
            begin
                stall     = rsp_hold_cycles;
                hold_done = 1'b1;
            end
            else
                stall = rsp_steady ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (rsp_ch.valid !== 1'b1);
        end
    end

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin : check_results
        list_reply_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result item with none expected: status %0d count %0d",
                       rsp_ch.status, rsp_ch.entry_count);
                n_errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    n_errors++;
                end
                if (rsp_ch.found_index !== want.found_index)
                begin
                    $error("found_index: expected %0d, got %0d",
                           want.found_index, rsp_ch.found_index);
                    n_errors++;
                end
                if (rsp_ch.out_key !== want.out_key)
                begin
                    $error("out_key: expected %h, got %h", want.out_key, rsp_ch.out_key);
                    n_errors++;
                end
                if (rsp_ch.out_payload !== want.out_payload)
                begin
                    $error("out_payload: expected %h, got %h",
                           want.out_payload, rsp_ch.out_payload);
                    n_errors++;
                end
                if (rsp_ch.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp_ch.entry_count);
                    n_errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item taken on either side
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // main sequence
    initial
    begin
        req_steady           = 1'b0;
        rsp_steady           = 1'b0;
        rsp_hold_cycles      = 0;
        mirror_count         = 0;
        rst_n                = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.kind          = '0;
        req_ch.position      = '0;
        req_ch.entry_key     = '0;
        req_ch.entry_payload = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_fill_and_edges();
        test_output_stall();
        test_random_traffic();

        req_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* bounded_array_list_engine_core.f */
design/bale_pkg.sv
design/bale_ifs.sv
design/bale_ctrl.sv
design/bale_dp.sv
design/bounded_array_list_engine_core.sv
dv/tb_bounded_array_list_engine_core.sv
